// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the line follower back pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lfpm_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpm_pkg
// Types, codes and limits shared by the line follower PID mixer.
// ----------------------------------------------------------------------------
package lfpm_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] CMD_FWD   = 2'd0;
  localparam logic [1:0] CMD_BACK  = 2'd1;
  localparam logic [1:0] CMD_RIGHT = 2'd2;
  localparam logic [1:0] CMD_LEFT  = 2'd3;

  localparam logic [2:0] REG_KP_FRONT   = 3'd0;
  localparam logic [2:0] REG_KD_FRONT   = 3'd1;
  localparam logic [2:0] REG_KP_SIDE    = 3'd2;
  localparam logic [2:0] REG_KI_SIDE    = 3'd3;
  localparam logic [2:0] REG_KD_SIDE    = 3'd4;
  localparam logic [2:0] REG_KP_HEADING = 3'd5;
  localparam logic [2:0] REG_KD_HEADING = 3'd6;
  localparam logic [2:0] REG_HEAD_TGT   = 3'd7;

  localparam int SIDE_LIM = 100;
  localparam int HEAD_LIM = 40;

  typedef struct packed {
    logic [7:0] kp_front;
    logic [7:0] kd_front;
    logic [7:0] kp_side;
    logic [7:0] ki_side;
    logic [7:0] kd_side;
    logic [7:0] kp_heading;
    logic [7:0] kd_heading;
  } gains_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [4:0]  e;
    logic signed [5:0]  de;
    logic signed [10:0] he;
    logic signed [11:0] dhe;
    logic [9:0]         x;
  } item_t;

endpackage

// ===== src/lfpm_front.sv =====
// ----------------------------------------------------------------------------
// lfpm_front
// Accepts input beats, decodes both sensor rows, tracks held and previous
// errors and pushes a classified work item into the queue.
// ----------------------------------------------------------------------------
module lfpm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_front_bits,
  input  logic [7:0]          in_side_bits,
  input  logic signed [9:0]   in_heading,
  input  logic [9:0]          in_base_speed,
  input  logic signed [9:0]   heading_target,
  input  logic                q_full,
  output logic                push,
  output lfpm_pkg::item_t     push_item
);
  import lfpm_pkg::*;

  logic signed [3:0]  front_err_r, front_err_nxt;
  logic signed [4:0]  side_err_r, side_err_nxt;
  logic signed [3:0]  prev_front_r;
  logic signed [4:0]  prev_side_r;
  logic signed [10:0] prev_head_r;
  logic signed [3:0]  fdec;
  logic signed [4:0]  sdec;
  logic               fhit, shit, side_sel;
  logic signed [10:0] he_raw, he_nxt;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    fhit = 1'b1;
    fdec = 4'sd0;
    case (in_front_bits[6:1])
      6'h01:   fdec = -4'sd6;
      6'h03:   fdec = -4'sd5;
      6'h02:   fdec = -4'sd3;
      6'h06:   fdec = -4'sd2;
      6'h04:   fdec = -4'sd1;
      6'h0C:   fdec = 4'sd0;
      6'h08:   fdec = 4'sd1;
      6'h18:   fdec = 4'sd2;
      6'h10:   fdec = 4'sd3;
      6'h30:   fdec = 4'sd5;
      6'h20:   fdec = 4'sd6;
      default: fhit = 1'b0;
    endcase
  end

  always_comb begin
    shit = 1'b1;
    sdec = 5'sd0;
    case (in_side_bits)
      8'h01:   sdec = -5'sd8;
      8'h03:   sdec = -5'sd7;
      8'h02:   sdec = -5'sd6;
      8'h06:   sdec = -5'sd5;
      8'h04:   sdec = -5'sd3;
      8'h0C:   sdec = -5'sd2;
      8'h08:   sdec = -5'sd1;
      8'h18:   sdec = 5'sd0;
      8'h10:   sdec = 5'sd1;
      8'h30:   sdec = 5'sd2;
      8'h20:   sdec = 5'sd3;
      8'h60:   sdec = 5'sd5;
      8'h40:   sdec = 5'sd6;
      8'hC0:   sdec = 5'sd7;
      8'h80:   sdec = 5'sd8;
      default: shit = 1'b0;
    endcase
  end

  always_comb begin
    front_err_nxt = fhit ? fdec : front_err_r;
    side_err_nxt  = shit ? sdec : side_err_r;
    side_sel      = in_command inside {CMD_RIGHT, CMD_LEFT};
    he_raw        = 11'(in_heading) - 11'(heading_target);
    he_nxt        = (he_raw inside {-11'sd1, 11'sd0, 11'sd1}) ? 11'sd0 : he_raw;

    push_item.cmd = in_command;
    push_item.x   = in_base_speed;
    push_item.he  = he_nxt;
    push_item.dhe = 12'(he_nxt) - 12'(prev_head_r);
    if (side_sel) begin
      push_item.e  = side_err_nxt;
      push_item.de = 6'(side_err_nxt) - 6'(prev_side_r);
    end else begin
      push_item.e  = 5'(front_err_nxt);
      push_item.de = 6'(front_err_nxt) - 6'(prev_front_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_err_r  <= '0;
      side_err_r   <= '0;
      prev_front_r <= '0;
      prev_side_r  <= '0;
      prev_head_r  <= '0;
    end else if (push) begin
      front_err_r <= front_err_nxt;
      side_err_r  <= side_err_nxt;
      prev_head_r <= he_nxt;
      if (side_sel) begin
        prev_side_r <= side_err_nxt;
      end else begin
        prev_front_r <= front_err_nxt;
      end
    end
  end

endmodule

// ===== src/lfpm_queue.sv =====
// ----------------------------------------------------------------------------
// lfpm_queue
// Short FIFO of work items between the front and back parts.
// ----------------------------------------------------------------------------
module lfpm_queue #(
  parameter int DEPTH = lfpm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lfpm_pkg::item_t  push_item,
  output logic             q_full,
  input  logic             pop,
  output lfpm_pkg::item_t  pop_item,
  output logic             q_empty
);
  import lfpm_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t           ent_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign q_full   = (cnt_r == CW'(DEPTH));
  assign q_empty  = (cnt_r == '0);
  assign pop_item = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

endmodule

// ===== src/lfpm_back.sv =====
// ----------------------------------------------------------------------------
// lfpm_back
// Four-stage PID and mixing pipeline: products, integrals, clamps, drives.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfpm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lfpm_pkg::gains_t     gains,
  input  logic                 q_empty,
  input  lfpm_pkg::item_t      pop_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_drive_one,
  output logic signed [15:0]   out_drive_two,
  output logic signed [15:0]   out_drive_three,
  output logic signed [15:0]   out_drive_four,
  output logic signed [15:0]   out_line_correction,
  output logic signed [6:0]    out_heading_correction
);
  import lfpm_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -33'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp34(input logic signed [33:0] v,
                                                 input int lo, input int hi);
    logic signed [15:0] r;
    if (v > 34'(hi)) begin
      r = 16'(hi);
    end else if (v < 34'(lo)) begin
      r = 16'(lo);
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  logic adv;

  // product stage
  logic               p_vld_r;
  logic [1:0]         p_cmd_r;
  logic [9:0]         p_x_r;
  logic signed [13:0] p_pl_r, p_pl_nxt, p_pi_r, p_pi_nxt;
  logic signed [14:0] p_dl_r, p_dl_nxt;
  logic signed [19:0] p_ph_r, p_ph_nxt;
  logic signed [20:0] p_dh_r, p_dh_nxt;
  logic [7:0]         kp_l, ki_l, kd_l;
  logic               q_side;

  // integral stage
  logic               i_vld_r;
  logic [1:0]         i_cmd_r;
  logic [9:0]         i_x_r;
  logic signed [31:0] i_lint_r, i_hint_r;
  logic signed [15:0] i_pdl_r;
  logic signed [21:0] i_phd_r;
  logic signed [31:0] fint_r, sint_r, hint_r;
  logic signed [31:0] lint_nxt, hint_nxt;
  logic               p_side;

  // clamp stage
  logic               c_vld_r;
  logic [1:0]         c_cmd_r;
  logic [9:0]         c_x_r;
  logic signed [15:0] c_l_r, c_l_nxt;
  logic signed [6:0]  c_a_r, c_a_nxt;
  logic signed [33:0] l_raw, a_raw;
  logic               i_side;

  // mix stage
  logic               o_vld_r;
  logic signed [17:0] xs, ls, as, ta, tb, tc, td;
  logic signed [17:0] m0, m1, m2, m3;

  assign adv = !o_vld_r || !out_stall;
  assign pop = adv && !q_empty;
  assign out_valid = o_vld_r;

  always_comb begin
    q_side   = pop_item.cmd inside {CMD_RIGHT, CMD_LEFT};
    kp_l     = q_side ? gains.kp_side : gains.kp_front;
    ki_l     = q_side ? gains.ki_side : gains.kp_front;
    kd_l     = q_side ? gains.kd_side : gains.kd_front;
    p_pl_nxt = 14'($signed({1'b0, kp_l})) * 14'(pop_item.e);
    p_pi_nxt = 14'($signed({1'b0, ki_l})) * 14'(pop_item.e);
    p_dl_nxt = 15'($signed({1'b0, kd_l})) * 15'(pop_item.de);
    p_ph_nxt = 20'($signed({1'b0, gains.kp_heading})) * 20'(pop_item.he);
    p_dh_nxt = 21'($signed({1'b0, gains.kd_heading})) * 21'(pop_item.dhe);
  end

  always_comb begin
    p_side   = p_cmd_r inside {CMD_RIGHT, CMD_LEFT};
    lint_nxt = sat32(33'(p_side ? sint_r : fint_r) + 33'(p_pi_r));
    hint_nxt = sat32(33'(hint_r) + 33'(p_ph_r));
  end

  always_comb begin
    i_side  = i_cmd_r inside {CMD_RIGHT, CMD_LEFT};
    l_raw   = 34'(i_lint_r) + 34'(i_pdl_r);
    a_raw   = 34'(i_hint_r) + 34'(i_phd_r);
    c_l_nxt = i_side ? clamp34(l_raw, -SIDE_LIM, SIDE_LIM) : clamp34(l_raw, -32768, 32767);
    c_a_nxt = 7'(clamp34(a_raw, -HEAD_LIM, HEAD_LIM));
  end

  always_comb begin
    xs = $signed({8'd0, c_x_r});
    ls = 18'(c_l_r);
    as = 18'(c_a_r);
    ta = xs - ls - as;
    tb = xs + ls - as;
    tc = xs + ls + as;
    td = xs - ls + as;
    case (c_cmd_r)
      CMD_FWD: begin
        m0 = ta;  m1 = -tb; m2 = -tc; m3 = td;
      end
      CMD_BACK, CMD_RIGHT: begin
        m0 = -tb; m1 = ta;  m2 = td;  m3 = -tc;
      end
      default: begin
        m0 = td;  m1 = -tc; m2 = -tb; m3 = ta;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
      fint_r  <= '0;
      sint_r  <= '0;
      hint_r  <= '0;
    end else if (adv) begin
      p_vld_r <= !q_empty;
      i_vld_r <= p_vld_r;
      c_vld_r <= i_vld_r;
      o_vld_r <= c_vld_r;
      if (p_vld_r) begin
        hint_r <= hint_nxt;
        if (p_side) begin
          sint_r <= lint_nxt;
        end else begin
          fint_r <= lint_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_cmd_r <= pop_item.cmd;
      p_x_r   <= pop_item.x;
      p_pl_r  <= p_pl_nxt;
      p_pi_r  <= p_pi_nxt;
      p_dl_r  <= p_dl_nxt;
      p_ph_r  <= p_ph_nxt;
      p_dh_r  <= p_dh_nxt;

      i_cmd_r  <= p_cmd_r;
      i_x_r    <= p_x_r;
      i_lint_r <= lint_nxt;
      i_hint_r <= hint_nxt;
      i_pdl_r  <= 16'(p_pl_r) + 16'(p_dl_r);
      i_phd_r  <= 22'(p_ph_r) + 22'(p_dh_r);

      c_cmd_r <= i_cmd_r;
      c_x_r   <= i_x_r;
      c_l_r   <= c_l_nxt;
      c_a_r   <= c_a_nxt;

      out_drive_one          <= sat16(m0);
      out_drive_two          <= sat16(m1);
      out_drive_three        <= sat16(m2);
      out_drive_four         <= sat16(m3);
      out_line_correction    <= c_l_r;
      out_heading_correction <= c_a_r;
    end
  end

  `ASSERT_IMP(a_head_rng, clk, rst_n, c_vld_r,
    (c_a_r <= 7'sd40) && (c_a_r >= -7'sd40), "heading correction out of range")
  `ASSERT_IMP(a_side_rng, clk, rst_n,
    c_vld_r && (c_cmd_r == CMD_RIGHT || c_cmd_r == CMD_LEFT),
    (c_l_r <= 16'sd100) && (c_l_r >= -16'sd100), "side correction out of range")
  `ASSERT_NXT(a_int_hold, clk, rst_n, !adv,
    $stable(fint_r) && $stable(sint_r) && $stable(hint_r), "integral moved while held")

endmodule

// ===== src/line_follow_pid_mixer.sv =====
// ----------------------------------------------------------------------------
// line_follow_pid_mixer
// Line follower control tick: sensor decode, front/side/heading PID and
// four-wheel mecanum drive mixing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one control tick per beat:
//   command, front and side sensor rows, measured heading and base speed.
//   Output channel (out_valid/out_stall) returns one beat per tick with the
//   four motor drives, the line correction and the heading correction.
//   Config channel (cfg_valid/cfg_ready) writes gains and heading target by
//   index; cfg_ready is always high. Write only while the block is idle.
//   Each result passes through the queue and the product, integral, clamp and mix stages.
//   Throughput: one beat per cycle while out_stall is low; the integral loops close in one stage.
//   When out_stall holds the output beat, the pipeline holds and the queue
//   fills; in_stall rises once the queue holds QUEUE_DEPTH items.
//   Reset clears the gains, held errors, integrals and all valid state.
// ----------------------------------------------------------------------------
module line_follow_pid_mixer #(
  parameter int QUEUE_DEPTH = lfpm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_front_bits,
  input  logic [7:0]         in_side_bits,
  input  logic signed [9:0]  in_heading,
  input  logic [9:0]         in_base_speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_drive_one,
  output logic signed [15:0] out_drive_two,
  output logic signed [15:0] out_drive_three,
  output logic signed [15:0] out_drive_four,
  output logic signed [15:0] out_line_correction,
  output logic signed [6:0]  out_heading_correction
);
  import lfpm_pkg::*;

  gains_t            gains_r;
  logic signed [9:0] head_tgt_r;
  logic              q_full, q_empty, push, pop;
  item_t             push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r    <= '0;
      head_tgt_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KP_FRONT:   gains_r.kp_front   <= cfg_data[7:0];
        REG_KD_FRONT:   gains_r.kd_front   <= cfg_data[7:0];
        REG_KP_SIDE:    gains_r.kp_side    <= cfg_data[7:0];
        REG_KI_SIDE:    gains_r.ki_side    <= cfg_data[7:0];
        REG_KD_SIDE:    gains_r.kd_side    <= cfg_data[7:0];
        REG_KP_HEADING: gains_r.kp_heading <= cfg_data[7:0];
        REG_KD_HEADING: gains_r.kd_heading <= cfg_data[7:0];
        REG_HEAD_TGT:   head_tgt_r         <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  lfpm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_front_bits  (in_front_bits),
    .in_side_bits   (in_side_bits),
    .in_heading     (in_heading),
    .in_base_speed  (in_base_speed),
    .heading_target (head_tgt_r),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  lfpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_empty   (q_empty)
  );

  lfpm_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .gains                  (gains_r),
    .q_empty                (q_empty),
    .pop_item               (pop_item),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_drive_one          (out_drive_one),
    .out_drive_two          (out_drive_two),
    .out_drive_three        (out_drive_three),
    .out_drive_four         (out_drive_four),
    .out_line_correction    (out_line_correction),
    .out_heading_correction (out_heading_correction)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line follower PID mixer. A short table of
// control ticks covers every sensor pattern, every direction and the field
// extremes, then random phases under different gain settings run about a
// thousand ticks with random gaps on both channels. Each tick is predicted
// from sensor decode, the three PID loops and the wheel mixing, and every
// output beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import lfpm_pkg::*;

  localparam int     QUIET_LIMIT    = 4000;
  localparam int     RANDOM_PHASES  = 8;
  localparam int     TICKS_PER_PHASE = 125;
  localparam int     FIRST_TUNED_ROW = 5;
  localparam longint I32_MAX        = 64'sd2147483647;
  localparam longint I32_MIN        = -I32_MAX - 1;

  localparam logic [5:0] FRONT_ROWS [11] = '{6'h01, 6'h03, 6'h02, 6'h06, 6'h04, 6'h0C,
                                             6'h08, 6'h18, 6'h10, 6'h30, 6'h20};
  localparam logic [7:0] SIDE_ROWS [15] = '{8'h01, 8'h03, 8'h02, 8'h06, 8'h04, 8'h0C,
                                            8'h08, 8'h18, 8'h10, 8'h30, 8'h20, 8'h60,
                                            8'h40, 8'hC0, 8'h80};

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        front;
    logic [7:0]        side;
    logic signed [9:0] heading;
    logic [9:0]        base;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] one;
    logic signed [15:0] two;
    logic signed [15:0] three;
    logic signed [15:0] four;
    logic signed [15:0] line;
    logic signed [6:0]  head;
  } drive_t;

  typedef struct packed {
    tick_t  t;
    logic   typed;
    drive_t want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_KP_FRONT;
  logic [9:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = CMD_FWD;
  logic [7:0]         in_front_bits = '0;
  logic [7:0]         in_side_bits = '0;
  logic signed [9:0]  in_heading = '0;
  logic [9:0]         in_base_speed = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_drive_one;
  logic signed [15:0] out_drive_two;
  logic signed [15:0] out_drive_three;
  logic signed [15:0] out_drive_four;
  logic signed [15:0] out_line_correction;
  logic signed [6:0]  out_heading_correction;

  gains_t            gains = '0;
  logic signed [9:0] head_target = '0;
  longint front_err = 0, side_err = 0, prev_front_err = 0, prev_side_err = 0;
  longint prev_head_err = 0, front_int = 0, side_int = 0, head_int = 0;
  longint front_out = 0, side_out = 0;

  drive_t pending_drives [$];
  drive_t due;
  int     mismatches = 0;
  int     quiet_cycles = 0;
  int     stall_left = 0;
  int     rx_pick;
  bit     tx_idle_en = 1'b1;
  bit     rx_idle_en = 1'b1;

  row_t steer_rows [17] = '{
    '{'{CMD_FWD,   8'h18, 8'h18,  10'sd0,    10'd0},    1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 7'sd0}},
    '{'{CMD_FWD,   8'hFF, 8'hFF,  10'sd511,  10'd1023}, 1'b1,
      '{16'sd1023, -16'sd1023, -16'sd1023, 16'sd1023, 16'sd0, 7'sd0}},
    '{'{CMD_BACK,  8'h02, 8'h01,  10'sh200,  10'd1023}, 1'b1,
      '{-16'sd1023, 16'sd1023, 16'sd1023, -16'sd1023, 16'sd0, 7'sd0}},
    '{'{CMD_RIGHT, 8'h40, 8'h80,  10'sd1,    10'd1023}, 1'b1,
      '{-16'sd1023, 16'sd1023, 16'sd1023, -16'sd1023, 16'sd0, 7'sd0}},
    '{'{CMD_LEFT,  8'h81, 8'h00, -10'sd1,    10'd1023}, 1'b1,
      '{16'sd1023, -16'sd1023, -16'sd1023, 16'sd1023, 16'sd0, 7'sd0}},
    '{'{CMD_FWD,   8'h06, 8'h03,  10'sd2,    10'd700},  1'b0, '0},
    '{'{CMD_BACK,  8'h04, 8'h02, -10'sd2,    10'd300},  1'b0, '0},
    '{'{CMD_RIGHT, 8'h0C, 8'h06,  10'sd360,  10'd512},  1'b0, '0},
    '{'{CMD_LEFT,  8'h88, 8'h04, -10'sd360,  10'd100},  1'b0, '0},
    '{'{CMD_FWD,   8'h10, 8'h0C,  10'sd45,   10'd1023}, 1'b0, '0},
    '{'{CMD_BACK,  8'h30, 8'h08, -10'sd90,   10'd0},    1'b0, '0},
    '{'{CMD_RIGHT, 8'h20, 8'h10,  10'sd180,  10'd256},  1'b0, '0},
    '{'{CMD_LEFT,  8'h61, 8'h30, -10'sd180,  10'd768},  1'b0, '0},
    '{'{CMD_FWD,   8'h7E, 8'h20,  10'sd90,   10'd900},  1'b0, '0},
    '{'{CMD_BACK,  8'h00, 8'h60,  10'sd0,    10'd50},   1'b0, '0},
    '{'{CMD_RIGHT, 8'h1B, 8'h40,  10'sd10,   10'd512},  1'b0, '0},
    '{'{CMD_LEFT,  8'h18, 8'hC0, -10'sd511,  10'd1}, 1'b0, '0}
  };

  line_follow_pid_mixer DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_front_bits          (in_front_bits),
    .in_side_bits           (in_side_bits),
    .in_heading             (in_heading),
    .in_base_speed          (in_base_speed),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_drive_one          (out_drive_one),
    .out_drive_two          (out_drive_two),
    .out_drive_three        (out_drive_three),
    .out_drive_four         (out_drive_four),
    .out_line_correction    (out_line_correction),
    .out_heading_correction (out_heading_correction)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    clip = v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit front_lookup(input logic [7:0] row, output int e);
    e = 0;
    front_lookup = 1'b1;
    case (row[6:1])
      6'h01: e = -6;
      6'h03: e = -5;
      6'h02: e = -3;
      6'h06: e = -2;
      6'h04: e = -1;
      6'h0C: e = 0;
      6'h08: e = 1;
      6'h18: e = 2;
      6'h10: e = 3;
      6'h30: e = 5;
      6'h20: e = 6;
      default: front_lookup = 1'b0;
    endcase
  endfunction

  function automatic bit side_lookup(input logic [7:0] row, output int e);
    e = 0;
    side_lookup = 1'b1;
    case (row)
      8'h01: e = -8;
      8'h03: e = -7;
      8'h02: e = -6;
      8'h06: e = -5;
      8'h04: e = -3;
      8'h0C: e = -2;
      8'h08: e = -1;
      8'h18: e = 0;
      8'h10: e = 1;
      8'h30: e = 2;
      8'h20: e = 3;
      8'h60: e = 5;
      8'h40: e = 6;
      8'hC0: e = 7;
      8'h80: e = 8;
      default: side_lookup = 1'b0;
    endcase
  endfunction

  task automatic step_controller(input tick_t t, output drive_t r);
    longint x, l, a, p, d, he, s0, s1, s2, s3;
    longint kpf, kdf, kps, kis, kds, kph, kdh;
    int e;
    kpf = longint'(gains.kp_front);
    kdf = longint'(gains.kd_front);
    kps = longint'(gains.kp_side);
    kis = longint'(gains.ki_side);
    kds = longint'(gains.kd_side);
    kph = longint'(gains.kp_heading);
    kdh = longint'(gains.kd_heading);
    x = longint'(t.base);
    if (front_lookup(t.front, e)) front_err = longint'(e);
    if (side_lookup(t.side, e)) side_err = longint'(e);
    if (t.cmd == CMD_FWD || t.cmd == CMD_BACK) begin
      p = kpf * front_err;
      front_int = clip(front_int + p, I32_MIN, I32_MAX);
      d = kdf * (front_err - prev_front_err);
      front_out = clip(p + front_int + d, -32768, 32767);
      prev_front_err = front_err;
      l = front_out;
    end else begin
      p = kps * side_err;
      side_int = clip(side_int + kis * side_err, I32_MIN, I32_MAX);
      d = kds * (side_err - prev_side_err);
      side_out = clip(p + side_int + d, -SIDE_LIM, SIDE_LIM);
      prev_side_err = side_err;
      l = side_out;
    end
    he = longint'($signed(t.heading)) - longint'($signed(head_target));
    if (he >= -1 && he <= 1) he = 0;
    p = he * kph;
    head_int = clip(head_int + p, I32_MIN, I32_MAX);
    d = (he - prev_head_err) * kdh;
    a = clip(p + head_int + d, -HEAD_LIM, HEAD_LIM);
    prev_head_err = he;
    case (t.cmd)
      CMD_FWD: begin
        s0 = x - l - a;
        s1 = -(x + l - a);
        s2 = -(x + l + a);
        s3 = x - l + a;
      end
      CMD_BACK, CMD_RIGHT: begin
        s0 = -(x + l - a);
        s1 = x - l - a;
        s2 = x - l + a;
        s3 = -(x + l + a);
      end
      default: begin
        s0 = x - l + a;
        s1 = -(x + l + a);
        s2 = -(x + l - a);
        s3 = x - l - a;
      end
    endcase
    r.one   = 16'(clip(s0, -32768, 32767));
    r.two   = 16'(clip(s1, -32768, 32767));
    r.three = 16'(clip(s2, -32768, 32767));
    r.four  = 16'(clip(s3, -32768, 32767));
    r.line  = 16'(l);
    r.head  = 7'(a);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
    if (!cfg_valid) cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_KP_FRONT:   gains.kp_front   = data[7:0];
      REG_KD_FRONT:   gains.kd_front   = data[7:0];
      REG_KP_SIDE:    gains.kp_side    = data[7:0];
      REG_KI_SIDE:    gains.ki_side    = data[7:0];
      REG_KD_SIDE:    gains.kd_side    = data[7:0];
      REG_KP_HEADING: gains.kp_heading = data[7:0];
      REG_KD_HEADING: gains.kd_heading = data[7:0];
      REG_HEAD_TGT:   head_target      = data;
      default: ;
    endcase
  endtask

  task automatic tune(input int kp_f, kd_f, kp_s, ki_s, kd_s, kp_h, kd_h, input int tgt);
    write_reg(REG_KP_FRONT,   {2'($urandom_range(0, 3)), 8'(kp_f)});
    write_reg(REG_KD_FRONT,   {2'($urandom_range(0, 3)), 8'(kd_f)});
    write_reg(REG_KP_SIDE,    {2'($urandom_range(0, 3)), 8'(kp_s)});
    write_reg(REG_KI_SIDE,    {2'($urandom_range(0, 3)), 8'(ki_s)});
    write_reg(REG_KD_SIDE,    {2'($urandom_range(0, 3)), 8'(kd_s)});
    write_reg(REG_KP_HEADING, {2'($urandom_range(0, 3)), 8'(kp_h)});
    write_reg(REG_KD_HEADING, {2'($urandom_range(0, 3)), 8'(kd_h)});
    write_reg(REG_HEAD_TGT,   10'(tgt));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input tick_t t, input logic typed, input drive_t want);
    drive_t predicted;
    int pick, gap;
    if (!in_valid) in_valid <= 1'b1;
    in_command    <= t.cmd;
    in_front_bits <= t.front;
    in_side_bits  <= t.side;
    in_heading    <= t.heading;
    in_base_speed <= t.base;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_controller(t, predicted);
    pending_drives.push_back(typed ? want : predicted);
    pick = $urandom_range(0, 99);
    gap = 0;
    if (tx_idle_en) begin
      if (pick >= 95) gap = $urandom_range(10, 40);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off new ticks until every outstanding beat has drained
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  function automatic tick_t random_tick();
    tick_t t;
    int pick, h;
    t.cmd = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 7)
      t.front = {1'($urandom_range(0, 1)), FRONT_ROWS[$urandom_range(0, 10)],
                 1'($urandom_range(0, 1))};
    else
      t.front = 8'($urandom);
    if ($urandom_range(0, 9) < 7) t.side = SIDE_ROWS[$urandom_range(0, 14)];
    else t.side = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 6) h = int'($urandom_range(0, 6)) - 3 + int'($signed(head_target));
    else if (pick < 9) h = int'($urandom_range(0, 720)) - 360;
    else h = int'($urandom_range(0, 1023)) - 512;
    if (h > 511) h = 511;
    if (h < -512) h = -512;
    t.heading = h[9:0];
    pick = $urandom_range(0, 19);
    if (pick == 0) t.base = '0;
    else if (pick == 1) t.base = 10'd1023;
    else t.base = 10'($urandom_range(0, 1023));
    return t;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t beat with nothing expected: expected none actual %0d", $time,
                   out_drive_one);
      end else begin
        due = pending_drives.pop_front();
        check_field("drive_one", int'(due.one), int'(out_drive_one));
        check_field("drive_two", int'(due.two), int'(out_drive_two));
        check_field("drive_three", int'(due.three), int'(out_drive_three));
        check_field("drive_four", int'(due.four), int'(out_drive_four));
        check_field("line_correction", int'(due.line), int'(out_line_correction));
        check_field("heading_correction", int'(due.head), int'(out_heading_correction));
      end
    end
  end

  always @(posedge clk) begin
    if (!rx_idle_en) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 70) begin
        out_stall <= 1'b0;
      end else if (rx_pick < 97) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 17; i++) begin
      if (i == FIRST_TUNED_ROW) begin
        settle();
        tune(255, 255, 255, 255, 255, 255, 255, 360);
      end
      send_tick(steer_rows[i].t, steer_rows[i].typed, steer_rows[i].want);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      tx_idle_en = (ph % 3 != 1);
      rx_idle_en = (ph % 3 != 2);
      case (ph)
        0: tune(255, 255, 255, 255, 255, 255, 255, -360);
        1: tune(0, 0, 0, 0, 0, 0, 0, 0);
        2: tune($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), int'($urandom_range(0, 1023)) - 512);
        3: tune(1, 1, 1, 1, 1, 1, 1, 511);
        default: tune($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 12),
                      $urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 12),
                      $urandom_range(0, 12), int'($urandom_range(0, 720)) - 360);
      endcase
      for (int n = 0; n < TICKS_PER_PHASE; n++)
        send_tick(random_tick(), 1'b0, '0);
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_drives.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/lfpm_pkg.sv
src/lfpm_front.sv
src/lfpm_queue.sv
src/lfpm_back.sv
src/line_follow_pid_mixer.sv
tb/tb_top.sv
